### sv/radio_packet_deframer_macros.svh
// assertion macros used by the deframer top level
// no dependencies; included inside the top-level module body
`ifndef RADIO_PACKET_DEFRAMER_MACROS_SVH
`define RADIO_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RPD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define RPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### sv/rpd_pkg.sv
// types and constants for the packet deframer
// no dependencies
package rpd_pkg;

    localparam int unsigned ADDR_W   = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PLEN_W   = 6;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 10;

    localparam int unsigned HDR_LEN     = 3;
    localparam int unsigned ACK_SENT_B  = 7;
    localparam int unsigned ACK_REQ_B   = 6;
    localparam logic [PLEN_W-1:0] PLEN_MAX = '1;

    localparam logic ITEM_HEADER  = 1'b0;
    localparam logic ITEM_PAYLOAD = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_NODE_ADDR  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SPY_MODE   = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_TARGET  = 5'b00010,
        PH_SENDER  = 5'b00100,
        PH_CTL     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } rpd_phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0] node_address;
        logic [ADDR_W-1:0] broadcast_address;
        logic              spy_mode;
    } rpd_cfg_t;

    typedef struct packed {
        logic              item_kind;
        logic              accepted;
        logic [ADDR_W-1:0] target_address;
        logic [ADDR_W-1:0] sender_address;
        logic              ack_flag;
        logic              ack_wanted;
        logic              ack_due;
        logic [PLEN_W-1:0] payload_length;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } rpd_result_t;

endpackage

### sv/rpd_parser.sv
// frame parser: phase and header state plus the per-beat result logic
// depends on rpd_pkg
module rpd_parser #(
    parameter int unsigned MAX_FRAME_LEN = 66
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      beat_en,
    input  logic [rpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                      frame_start,
    input  rpd_pkg::rpd_cfg_t         cfg,
    output logic                      res_valid,
    output rpd_pkg::rpd_result_t      res
);
    import rpd_pkg::*;

    localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_FRAME_LEN);
    localparam logic [BYTE_W-1:0] HdrLen = BYTE_W'(HDR_LEN);

    rpd_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0] clamped_length_reg, clamped_length_next;
    logic [BYTE_W-1:0] target_low_reg, target_low_next;
    logic [BYTE_W-1:0] sender_low_reg, sender_low_next;
    logic [PLEN_W-1:0] bytes_left_reg, bytes_left_next;

    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] snd;
    logic              addr_hit;
    logic              acc;
    logic [BYTE_W-1:0] len_diff;
    logic [PLEN_W-1:0] plen;
    logic [PLEN_W-1:0] bytes_dec;

    assign tgt      = {rx_byte[3:2], target_low_reg};
    assign snd      = {rx_byte[1:0], sender_low_reg};
    assign addr_hit = cfg.spy_mode || (tgt == cfg.node_address)
                      || (tgt == cfg.broadcast_address);
    assign acc      = addr_hit && (clamped_length_reg >= HdrLen);
    assign len_diff = clamped_length_reg - HdrLen;
    assign plen     = !acc ? '0
                    : (len_diff > BYTE_W'(PLEN_MAX)) ? PLEN_MAX
                    : len_diff[PLEN_W-1:0];
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - PLEN_W'(1) : '0;

    always_comb begin
        phase_next          = phase_reg;
        clamped_length_next = clamped_length_reg;
        target_low_next     = target_low_reg;
        sender_low_next     = sender_low_reg;
        bytes_left_next     = bytes_left_reg;
        res_valid           = 1'b0;
        res                 = '0;
        if (beat_en) begin
            if (frame_start) begin
                clamped_length_next = (rx_byte > MaxLen) ? MaxLen : rx_byte;
                bytes_left_next     = '0;
                phase_next          = PH_TARGET;
            end else begin
                unique case (phase_reg)
                    PH_TARGET: begin
                        target_low_next = rx_byte;
                        phase_next      = PH_SENDER;
                    end
                    PH_SENDER: begin
                        sender_low_next = rx_byte;
                        phase_next      = PH_CTL;
                    end
                    PH_CTL: begin
                        res_valid          = 1'b1;
                        res.item_kind      = ITEM_HEADER;
                        res.accepted       = acc;
                        res.target_address = tgt;
                        res.sender_address = snd;
                        res.ack_flag       = acc && rx_byte[ACK_SENT_B];
                        res.ack_wanted     = acc && rx_byte[ACK_REQ_B];
                        res.ack_due        = acc && rx_byte[ACK_REQ_B]
                                             && (tgt == cfg.node_address);
                        res.payload_length = plen;
                        res.last           = (plen == '0);
                        bytes_left_next    = plen;
                        phase_next         = (plen != '0) ? PH_PAYLOAD : PH_IDLE;
                    end
                    PH_PAYLOAD: begin
                        res_valid       = 1'b1;
                        res.item_kind   = ITEM_PAYLOAD;
                        res.data_byte   = rx_byte;
                        res.last        = (bytes_dec == '0);
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == '0) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            clamped_length_reg <= '0;
            target_low_reg     <= '0;
            sender_low_reg     <= '0;
            bytes_left_reg     <= '0;
        end else begin
            phase_reg          <= phase_next;
            clamped_length_reg <= clamped_length_next;
            target_low_reg     <= target_low_next;
            sender_low_reg     <= sender_low_next;
            bytes_left_reg     <= bytes_left_next;
        end
    end

endmodule

### sv/radio_packet_deframer.sv
// channel    | direction | beat contents
// s_         | in        | rx_byte, frame_start
// m_         | out       | header summary or payload byte, last mark
// cfg_       | in        | write of node, broadcast address or spy mode
//
// one beat per cycle while s_ready is high; each accepted input beat gives its result,
// if any, in the next cycle from the output register
// reset is synchronous, active low, and returns the parser to idle
// the input side keeps taking beats while the output register is empty
// or being drained, so a stall on m_ready costs only the held beat
// top level of the deframer; depends on rpd_pkg, rpd_parser and the macros header
module radio_packet_deframer #(
    parameter int unsigned MAX_FRAME_LEN = 66
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rpd_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [rpd_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rpd_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic                        s_frame_start,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_item_kind,
    output logic                        m_accepted,
    output logic [rpd_pkg::ADDR_W-1:0]  m_target_address,
    output logic [rpd_pkg::ADDR_W-1:0]  m_sender_address,
    output logic                        m_ack_flag,
    output logic                        m_ack_wanted,
    output logic                        m_ack_due,
    output logic [rpd_pkg::PLEN_W-1:0]  m_payload_length,
    output logic [rpd_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                        m_last
);
    import rpd_pkg::*;
    `include "radio_packet_deframer_macros.svh"

    rpd_cfg_t    cfg_reg, cfg_next;
    logic        m_valid_reg, m_valid_next;
    rpd_result_t out_reg, out_next;
    logic        beat_en;
    logic        res_valid;
    rpd_result_t res;

    assign s_ready = !m_valid_reg || m_ready;
    assign beat_en = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_NODE_ADDR:  cfg_next.node_address      = cfg_wdata[ADDR_W-1:0];
                CFG_BCAST_ADDR: cfg_next.broadcast_address = cfg_wdata[ADDR_W-1:0];
                CFG_SPY_MODE:   cfg_next.spy_mode          = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    rpd_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_en     (beat_en),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (s_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_item_kind      = out_reg.item_kind;
    assign m_accepted       = out_reg.accepted;
    assign m_target_address = out_reg.target_address;
    assign m_sender_address = out_reg.sender_address;
    assign m_ack_flag       = out_reg.ack_flag;
    assign m_ack_wanted     = out_reg.ack_wanted;
    assign m_ack_due        = out_reg.ack_due;
    assign m_payload_length = out_reg.payload_length;
    assign m_data_byte      = out_reg.data_byte;
    assign m_last           = out_reg.last;

    // rejected header closes the frame with nothing to follow
    `RPD_ASSERT_NOW(a_reject_closes, aclk, aresetn,
        m_valid_reg && (out_reg.item_kind == ITEM_HEADER) && !out_reg.accepted,
        out_reg.last && (out_reg.payload_length == '0) && !out_reg.ack_due)
    // ack due only for own address with a request
    `RPD_ASSERT_NOW(a_ack_due_own, aclk, aresetn,
        m_valid_reg && out_reg.ack_due,
        out_reg.ack_wanted && (out_reg.target_address == cfg_reg.node_address))
    // a frame start beat never yields a result
    `RPD_ASSERT_NEXT(a_start_silent, aclk, aresetn,
        beat_en && s_frame_start,
        !m_valid_reg)

endmodule

### verif/radio_packet_deframer_checker.sv
`timescale 1ns / 100ps
// result checker for radio_packet_deframer: tracks register writes and input beats,
// decodes the expected header and payload results, and compares every output beat
// depends on rpd_pkg
module radio_packet_deframer_checker #(
    parameter int unsigned MAX_FRAME_LEN = 66
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rpd_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [rpd_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [rpd_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic                        s_frame_start,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_item_kind,
    input  logic                        m_accepted,
    input  logic [rpd_pkg::ADDR_W-1:0]  m_target_address,
    input  logic [rpd_pkg::ADDR_W-1:0]  m_sender_address,
    input  logic                        m_ack_flag,
    input  logic                        m_ack_wanted,
    input  logic                        m_ack_due,
    input  logic [rpd_pkg::PLEN_W-1:0]  m_payload_length,
    input  logic [rpd_pkg::BYTE_W-1:0]  m_data_byte,
    input  logic                        m_last,
    output int                          err_count,
    output int                          results_due,
    output int                          header_count,
    output int                          accepted_count,
    output int                          payload_count
);
    import rpd_pkg::*;

    logic [ADDR_W-1:0] node_addr;
    logic [ADDR_W-1:0] bcast_addr;
    logic              spy_on;

    rpd_phase_t        phase;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] target_lo;
    logic [BYTE_W-1:0] sender_lo;
    logic [PLEN_W-1:0] bytes_left;

    rpd_result_t       due_results[$];

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic decode_rx_byte(input logic [BYTE_W-1:0] b, input logic start);
        rpd_result_t       r;
        logic [ADDR_W-1:0] tgt;
        logic [ADDR_W-1:0] snd;
        logic              ok;
        logic [BYTE_W-1:0] plen;
        r = '0;
        if (start) begin
            frame_len  = (b > MAX_FRAME_LEN) ? BYTE_W'(MAX_FRAME_LEN) : b;
            bytes_left = '0;
            phase      = PH_TARGET;
        end else begin
            case (phase)
                PH_TARGET: begin
                    target_lo = b;
                    phase     = PH_SENDER;
                end
                PH_SENDER: begin
                    sender_lo = b;
                    phase     = PH_CTL;
                end
                PH_CTL: begin
                    tgt = {b[3:2], target_lo};
                    snd = {b[1:0], sender_lo};
                    ok  = (spy_on || tgt == node_addr || tgt == bcast_addr)
                          && frame_len >= HDR_LEN;
                    r.item_kind      = ITEM_HEADER;
                    r.accepted       = ok;
                    r.target_address = tgt;
                    r.sender_address = snd;
                    if (ok) begin
                        plen             = frame_len - BYTE_W'(HDR_LEN);
                        r.payload_length = (plen > PLEN_MAX) ? PLEN_MAX : plen[PLEN_W-1:0];
                        r.ack_flag       = b[ACK_SENT_B];
                        r.ack_wanted     = b[ACK_REQ_B];
                        r.ack_due        = b[ACK_REQ_B] && tgt == node_addr;
                    end
                    r.last     = (r.payload_length == 0);
                    bytes_left = r.payload_length;
                    phase      = (bytes_left != 0) ? PH_PAYLOAD : PH_IDLE;
                    due_results.push_back(r);
                end
                PH_PAYLOAD: begin
                    r.item_kind = ITEM_PAYLOAD;
                    r.data_byte = b;
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 1'b1;
                    r.last = (bytes_left == 0);
                    if (bytes_left == 0)
                        phase = PH_IDLE;
                    due_results.push_back(r);
                end
                default: phase = PH_IDLE;
            endcase
        end
    endtask

    task automatic check_result();
        rpd_result_t got;
        rpd_result_t want;
        got = {m_item_kind, m_accepted, m_target_address, m_sender_address,
               m_ack_flag, m_ack_wanted, m_ack_due, m_payload_length,
               m_data_byte, m_last};
        if (due_results.size() == 0) begin
            flag_mismatch("result beat with none outstanding", 64'(got), '0);
        end else begin
            want = due_results.pop_front();
            if (got.item_kind !== want.item_kind)
                flag_mismatch("item_kind", 64'(got.item_kind), 64'(want.item_kind));
            if (got.accepted !== want.accepted)
                flag_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
            if (got.target_address !== want.target_address)
                flag_mismatch("target_address", 64'(got.target_address),
                              64'(want.target_address));
            if (got.sender_address !== want.sender_address)
                flag_mismatch("sender_address", 64'(got.sender_address),
                              64'(want.sender_address));
            if (got.ack_flag !== want.ack_flag)
                flag_mismatch("ack_flag", 64'(got.ack_flag), 64'(want.ack_flag));
            if (got.ack_wanted !== want.ack_wanted)
                flag_mismatch("ack_wanted", 64'(got.ack_wanted), 64'(want.ack_wanted));
            if (got.ack_due !== want.ack_due)
                flag_mismatch("ack_due", 64'(got.ack_due), 64'(want.ack_due));
            if (got.payload_length !== want.payload_length)
                flag_mismatch("payload_length", 64'(got.payload_length),
                              64'(want.payload_length));
            if (got.data_byte !== want.data_byte)
                flag_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
            if (got.last !== want.last)
                flag_mismatch("last", 64'(got.last), 64'(want.last));
            if (want.item_kind == ITEM_HEADER) begin
                header_count++;
                if (want.accepted)
                    accepted_count++;
            end else begin
                payload_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            node_addr  = '0;
            bcast_addr = '0;
            spy_on     = 1'b0;
            phase      = PH_IDLE;
            frame_len  = '0;
            target_lo  = '0;
            sender_lo  = '0;
            bytes_left = '0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_NODE_ADDR:  node_addr  = cfg_wdata[ADDR_W-1:0];
                    CFG_BCAST_ADDR: bcast_addr = cfg_wdata[ADDR_W-1:0];
                    CFG_SPY_MODE:   spy_on     = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                decode_rx_byte(s_rx_byte, s_frame_start);
        end
        results_due = due_results.size();
    end

endmodule

### verif/radio_packet_deframer_tb.sv
`timescale 1ns / 100ps
// testbench top for radio_packet_deframer: clock, reset, register setup, frame stimulus,
// output stalls and the final verdict; checking is done by radio_packet_deframer_checker
// depends on rpd_pkg, the deframer rtl and the checker module
module radio_packet_deframer_tb;
    import rpd_pkg::*;

    localparam int unsigned FRAME_MAX      = 66;
    localparam int          CFG_ROUNDS     = 6;
    localparam int          BEATS_PER_ROUND = 125;
    localparam int          HOLD_AT        = 400;
    localparam int          HOLD_LEN       = 120;
    localparam int          SETTLE_CYCLES  = 4;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_AW-1:0] cfg_addr      = '0;
    logic [CFG_DW-1:0] cfg_wdata     = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte     = '0;
    logic              s_frame_start = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_item_kind;
    logic              m_accepted;
    logic [ADDR_W-1:0] m_target_address;
    logic [ADDR_W-1:0] m_sender_address;
    logic              m_ack_flag;
    logic              m_ack_wanted;
    logic              m_ack_due;
    logic [PLEN_W-1:0] m_payload_length;
    logic [BYTE_W-1:0] m_data_byte;
    logic              m_last;

    int err_count;
    int results_due;
    int header_count;
    int accepted_count;
    int payload_count;

    logic [ADDR_W-1:0] cur_node  = '0;
    logic [ADDR_W-1:0] cur_bcast = '0;
    logic              cur_spy   = 1'b0;
    int                burst_left = 0;
    int                round_beats;
    int                total_beats = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    radio_packet_deframer #(.MAX_FRAME_LEN(FRAME_MAX)) dut (.*);

    radio_packet_deframer_checker #(.MAX_FRAME_LEN(FRAME_MAX)) checker_i (.*);

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic st);
        s_rx_byte     = b;
        s_frame_start = st;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        total_beats++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                s_valid       = 1'b0;
                s_rx_byte     = BYTE_W'($urandom);
                s_frame_start = 1'($urandom);
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_config(input logic [ADDR_W-1:0] node, input logic [ADDR_W-1:0] bcast,
                               input logic spy);
        cur_node  = node;
        cur_bcast = bcast;
        cur_spy   = spy;
        cfg_wr_en = 1'b1;
        cfg_addr  = CFG_NODE_ADDR;
        cfg_wdata = node;
        @(negedge aclk);
        cfg_addr  = CFG_BCAST_ADDR;
        cfg_wdata = bcast;
        @(negedge aclk);
        cfg_addr  = CFG_SPY_MODE;
        cfg_wdata = {{(CFG_DW-1){1'b0}}, spy};
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // mostly well-formed frames; some cut short by the next frame start, some with stray bytes
    task automatic send_frame();
        int unsigned       len_sel;
        int unsigned       n_pay;
        int unsigned       cut;
        logic [BYTE_W-1:0] len_b;
        logic [BYTE_W-1:0] ctl;
        logic [ADDR_W-1:0] tgt;
        len_sel = $urandom_range(0, 99);
        if (len_sel < 8)
            len_b = BYTE_W'($urandom_range(0, 2));
        else if (len_sel < 80)
            len_b = BYTE_W'($urandom_range(3, 12));
        else if (len_sel < 95)
            len_b = BYTE_W'($urandom_range(13, FRAME_MAX));
        else
            len_b = BYTE_W'($urandom_range(FRAME_MAX + 1, 255));
        case ($urandom_range(0, 4))
            0, 1:    tgt = cur_node;
            2:       tgt = cur_bcast;
            default: tgt = ADDR_W'($urandom_range(0, 1023));
        endcase
        ctl      = BYTE_W'($urandom);
        ctl[3:2] = tgt[9:8];
        n_pay = (len_b > FRAME_MAX) ? FRAME_MAX : len_b;
        n_pay = (n_pay >= HDR_LEN) ? n_pay - HDR_LEN : 0;
        cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_pay + 3) : n_pay + 4;
        for (int i = 0; i < n_pay + 4 && i < cut; i++) begin
            case (i)
                0:       send_beat(len_b, 1'b1);
                1:       send_beat(tgt[7:0], 1'b0);
                2:       send_beat(BYTE_W'($urandom), 1'b0);
                3:       send_beat(ctl, 1'b0);
                default: send_beat(BYTE_W'($urandom), 1'b0);
            endcase
            round_beats++;
        end
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3)) send_beat(BYTE_W'($urandom), 1'b0);
    endtask

    initial begin : result_side
        int          cyc;
        logic [15:0] stall_mask;
        cyc        = 0;
        stall_mask = '1;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc == HOLD_AT) begin
                m_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                cyc += HOLD_LEN;
            end
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_mask = '1;
                    1:       stall_mask = 16'($urandom);
                    2:       stall_mask = 16'($urandom | $urandom);
                    default: stall_mask = 16'($urandom & $urandom);
                endcase
            end
            m_ready = stall_mask[cyc % 16];
        end
    end

    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] rnd_node;
        logic [ADDR_W-1:0] rnd_bcast;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: node and broadcast both 0, spy off
        send_beat(8'hFF, 1'b0);
        send_beat(8'h03, 1'b1); send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0); send_beat(8'hC3, 1'b0);
        send_beat(8'h02, 1'b1); send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
        send_beat(8'h05, 1'b1); send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0); send_beat(8'h8C, 1'b0);
        send_beat(8'h12, 1'b0); send_beat(8'h34, 1'b0);
        send_beat(8'h05, 1'b1); send_beat(8'h00, 1'b0);
        send_beat(8'h7E, 1'b0); send_beat(8'h40, 1'b0);
        send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0);
        send_beat(8'h09, 1'b1); send_beat(8'h00, 1'b0);
        send_beat(8'h04, 1'b1); send_beat(8'h00, 1'b0);
        send_beat(8'h55, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(8'hAA, 1'b0);

        for (int r = 0; r < CFG_ROUNDS; r++) begin
            wait_idle();
            rnd_node  = ADDR_W'($urandom_range(0, 1023));
            rnd_bcast = ADDR_W'($urandom_range(0, 1023));
            case (r)
                0:       load_config('1, '0, 1'b0);
                1:       load_config('0, '1, 1'b1);
                2:       load_config(rnd_node, rnd_bcast, 1'b0);
                3:       load_config(rnd_node, rnd_node, 1'b0);
                4:       load_config(rnd_node, rnd_bcast, 1'b1);
                default: load_config(rnd_node, rnd_bcast, 1'($urandom));
            endcase
            round_beats = 0;
            while (round_beats < BEATS_PER_ROUND) send_frame();
        end
        wait_idle();

        $display("covered %0d input beats over %0d register settings, incl. a long output hold",
                 total_beats, CFG_ROUNDS + 1);
        $display("checked %0d headers (%0d accepted) and %0d payload bytes",
                 header_count, accepted_count, payload_count);
        if (err_count == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
